// ----- rtl/itdp_pkg.sv -----
// Shared types and constants for the integer to padded decimal text converter.
package itdp_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned WidthW     = 6;
  localparam int unsigned CharW      = 8;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BcdW       = 4 * NumDigits;
  localparam int unsigned StepW      = $clog2(ValueW);
  localparam int unsigned DigitIdxW  = $clog2(NumDigits);
  localparam int unsigned TextLenW   = $clog2(NumDigits + 2);
  localparam int unsigned InDataW    = ((ValueW + WidthW + 7) / 8) * 8;

  localparam logic [WidthW-1:0] WidthLimit = WidthW'(32);

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharBlank = 8'h20;

  typedef logic [BcdW-1:0]   bcd_t;
  typedef logic [ValueW-1:0] mag_t;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSize,
    StEmit
  } state_e;

endpackage

// ----- rtl/itdp_dabble.sv -----
// One double-dabble step: add-3 correction on each BCD digit, then shift in one binary bit.
module itdp_dabble (
  input  itdp_pkg::bcd_t bcd_i,
  input  itdp_pkg::mag_t bin_i,
  output itdp_pkg::bcd_t bcd_o,
  output itdp_pkg::mag_t bin_o
);

  itdp_pkg::bcd_t adj;

  always_comb begin
    for (int i = 0; i < int'(itdp_pkg::NumDigits); i++) begin
      if (bcd_i[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_i[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_i[i*4 +: 4];
      end
    end
  end

  assign bcd_o = {adj[itdp_pkg::BcdW-2:0], bin_i[itdp_pkg::ValueW-1]};
  assign bin_o = {bin_i[itdp_pkg::ValueW-2:0], 1'b0};

endmodule

// ----- rtl/int_to_decimal_padded.sv -----
// Signed 32-bit integer to right-justified decimal ASCII text, one character per output item.
// An input item is converted by one pass per magnitude bit through one shared double-dabble
// step (add-3, shift), then the sizing state sizes the text, then the characters leave at one
// per cycle while the output is not stalled: leading blanks up to min_width (saturated at 32),
// a minus sign for negative values, then the digits, with tlast on the final character. The
// input is ready only in the idle state, so no new item is taken while the conversion, the
// sizing or the emission of characters of an item is in flight. The last character may still
// wait in the output register while the next item is taken in.
module int_to_decimal_padded (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] value (signed), [37:32] min_width, [39:38] zero
  input  logic [itdp_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] text_char
  output logic [itdp_pkg::CharW-1:0]      m_axis_tdata,
  output logic                            m_axis_tlast
);

  localparam int unsigned ValueW = itdp_pkg::ValueW;
  localparam int unsigned WidthW = itdp_pkg::WidthW;

  itdp_pkg::state_e state_q, state_d;

  logic [itdp_pkg::StepW-1:0]    step_q, step_d;
  logic [WidthW-1:0]             pos_q, pos_d;
  logic [WidthW-1:0]             width_q, width_d;
  logic [WidthW-1:0]             total_q, total_d;
  logic [WidthW-1:0]             pad_q, pad_d;
  logic                          neg_q, neg_d;
  itdp_pkg::bcd_t                bcd_q, bcd_d;
  itdp_pkg::mag_t                bin_q, bin_d;

  logic                          m_valid_q, m_valid_d;
  logic [itdp_pkg::CharW-1:0]    m_data_q, m_data_d;
  logic                          m_last_q, m_last_d;

  itdp_pkg::bcd_t                step_bcd;
  itdp_pkg::mag_t                step_bin;

  logic [ValueW-1:0]             in_value;
  logic [WidthW-1:0]             in_width;
  logic                          in_neg;
  logic                          accept;
  logic                          can_load;

  logic [itdp_pkg::TextLenW-1:0] ndig;
  logic [WidthW-1:0]             textlen;
  logic [WidthW-1:0]             total_c;
  logic [itdp_pkg::DigitIdxW-1:0] didx;
  logic [WidthW-1:0]             didx_full;
  logic [itdp_pkg::CharW-1:0]    cur_char;
  logic                          cur_last;

  itdp_dabble u_dabble (
    .bcd_i (bcd_q),
    .bin_i (bin_q),
    .bcd_o (step_bcd),
    .bin_o (step_bin)
  );

  assign in_value = s_axis_tdata[ValueW-1:0];
  assign in_width = s_axis_tdata[ValueW +: WidthW];
  assign in_neg   = in_value[ValueW-1];

  assign s_axis_tready = (state_q == itdp_pkg::StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign can_load      = !m_valid_q || m_axis_tready;

  // digit count: highest nonzero BCD digit, at least one
  always_comb begin
    ndig = itdp_pkg::TextLenW'(1);
    for (int i = 1; i < int'(itdp_pkg::NumDigits); i++) begin
      if (bcd_q[i*4 +: 4] != 4'd0) begin
        ndig = itdp_pkg::TextLenW'(i + 1);
      end
    end
  end

  assign textlen = WidthW'(ndig) + WidthW'(neg_q);
  assign total_c = (width_q > textlen) ? width_q : textlen;

  assign didx_full = total_q - pos_q - WidthW'(1);
  assign didx      = didx_full[itdp_pkg::DigitIdxW-1:0];

  always_comb begin
    if (pos_q < pad_q) begin
      cur_char = itdp_pkg::CharBlank;
    end else if (neg_q && (pos_q == pad_q)) begin
      cur_char = itdp_pkg::CharMinus;
    end else begin
      cur_char = itdp_pkg::CharZero + itdp_pkg::CharW'(bcd_q[didx*4 +: 4]);
    end
  end

  assign cur_last = (pos_q == total_q - WidthW'(1));

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    pos_d     = pos_q;
    width_d   = width_q;
    total_d   = total_q;
    pad_d     = pad_q;
    neg_d     = neg_q;
    bcd_d     = bcd_q;
    bin_d     = bin_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;

    unique case (state_q)
      itdp_pkg::StIdle: begin
        if (accept) begin
          neg_d   = in_neg;
          bin_d   = in_neg ? (ValueW'(0) - in_value) : in_value;
          width_d = (in_width > itdp_pkg::WidthLimit) ? itdp_pkg::WidthLimit : in_width;
          bcd_d   = '0;
          step_d  = '0;
          state_d = itdp_pkg::StConv;
        end
      end
      itdp_pkg::StConv: begin
        bcd_d  = step_bcd;
        bin_d  = step_bin;
        step_d = step_q + itdp_pkg::StepW'(1);
        if (step_q == itdp_pkg::StepW'(ValueW - 1)) begin
          state_d = itdp_pkg::StSize;
        end
      end
      itdp_pkg::StSize: begin
        total_d = total_c;
        pad_d   = total_c - textlen;
        pos_d   = '0;
        state_d = itdp_pkg::StEmit;
      end
      itdp_pkg::StEmit: begin
        if (can_load) begin
          m_valid_d = 1'b1;
          m_data_d  = cur_char;
          m_last_d  = cur_last;
          pos_d     = pos_q + WidthW'(1);
          if (cur_last) begin
            state_d = itdp_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = itdp_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= itdp_pkg::StIdle;
      step_q    <= '0;
      pos_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      pos_q     <= pos_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    width_q  <= width_d;
    total_q  <= total_d;
    pad_q    <= pad_d;
    neg_q    <= neg_d;
    bcd_q    <= bcd_d;
    bin_q    <= bin_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=>
      (state_q == itdp_pkg::StConv && step_q == '0))
    else $error("accepted item did not start conversion");

  a_size_after_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itdp_pkg::StSize) |-> ($past(state_q) == itdp_pkg::StConv))
    else $error("sizing entered without finished conversion");

  a_emit_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itdp_pkg::StEmit) |->
      (total_q != '0 && total_q <= itdp_pkg::WidthLimit && pad_q < total_q &&
       pos_q < total_q))
    else $error("emit counters out of range");

endmodule
